/* rtl/core/eau_pkg.sv */
package eau_pkg;

    localparam int NumCells = 16;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_ASH  = 2'd2,
        OP_ASHC = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] reg_high_in;
        logic [15:0] reg_low_in;
        logic        reg_is_odd;
        logic [15:0] source_word;
        logic [3:0]  flags_in;
    } t_in;

    typedef struct packed {
        logic [15:0] result_high;
        logic [15:0] result_low;
        logic        write_high;
        logic        write_low;
        logic [3:0]  flags_out;
    } t_out;

    // Data handed from one cell to the next. The divide iterates with the
    // magnitudes: rem is a 17-bit partial remainder, dvd shifts quotient bits in.
    // ovf marks a quotient magnitude that cannot fit in 16 bits.
    typedef struct packed {
        logic        vld;
        t_op         op;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] src;
        logic [3:0]  fin;
        logic [16:0] rem;
        logic [31:0] dvd;
        logic [15:0] dmag;
        logic        sdvd;
        logic        sdiv;
        logic        ovf;
    } t_stage;

endpackage

/* rtl/core/eau_cell.sv */
// One restoring divide step; every other operation passes through with only dvd shifted.
module eau_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eau_pkg::t_stage i_d,
    output eau_pkg::t_stage o_d
);

    eau_pkg::t_stage n_d;
    eau_pkg::t_stage r_d;
    logic [17:0]     w_try;
    logic [16:0]     w_sh;

    always_comb begin
        n_d   = i_d;
        w_sh  = {i_d.rem[15:0], i_d.dvd[31]};
        w_try = {1'b0, w_sh} - {2'b00, i_d.dmag};
        n_d.dvd = {i_d.dvd[30:0], 1'b0};
        if (i_d.op == eau_pkg::OP_DIV) begin
            if (!w_try[17]) begin
                n_d.rem    = w_try[16:0];
                n_d.dvd[0] = 1'b1;
            end else begin
                n_d.rem = w_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= i_d.vld;
        end
        r_d.op   <= n_d.op;
        r_d.hi   <= n_d.hi;
        r_d.lo   <= n_d.lo;
        r_d.src  <= n_d.src;
        r_d.fin  <= n_d.fin;
        r_d.rem  <= n_d.rem;
        r_d.dvd  <= n_d.dvd;
        r_d.dmag <= n_d.dmag;
        r_d.sdvd <= n_d.sdvd;
        r_d.sdiv <= n_d.sdiv;
        r_d.ovf  <= n_d.ovf;
    end

    assign o_d = r_d;

endmodule

/* rtl/core/eau_front.sv */
// Entry stage: operand setup; divide starts with the first 16 dividend
// bits already in the remainder, so a high half not below the divisor
// means the quotient overflows and is flagged here.
module eau_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  eau_pkg::t_in    i_item,
    output eau_pkg::t_stage o_d
);

    eau_pkg::t_stage r_d;
    logic [15:0]     w_lo;
    logic [31:0]     w_pair;
    logic [31:0]     w_mag;
    logic [15:0]     w_dm;

    always_comb begin
        w_lo   = i_item.reg_is_odd ? i_item.reg_high_in : i_item.reg_low_in;
        w_pair = {i_item.reg_high_in, w_lo};
        w_mag  = w_pair[31] ? (32'd0 - w_pair) : w_pair;
        w_dm   = i_item.source_word[15] ? (16'd0 - i_item.source_word)
                                        : i_item.source_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= i_go;
        end
        r_d.op   <= eau_pkg::t_op'(i_item.req_type);
        r_d.hi   <= i_item.reg_high_in;
        r_d.lo   <= w_lo;
        r_d.src  <= i_item.source_word;
        r_d.fin  <= i_item.flags_in;
        r_d.rem  <= {1'b0, w_mag[31:16]};
        r_d.dvd  <= {w_mag[15:0], 16'd0};
        r_d.dmag <= w_dm;
        r_d.sdvd <= w_pair[31];
        r_d.sdiv <= i_item.source_word[15];
        r_d.ovf  <= (w_mag[31:16] >= w_dm);
    end

    assign o_d = r_d;

endmodule

/* rtl/core/eau_back.sv */
// Final stage: multiply, shifts and divide sign fixup and flags.
module eau_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eau_pkg::t_stage i_d,
    output logic            o_done,
    output eau_pkg::t_out   o_result
);

    eau_pkg::t_out r_res;
    logic          r_done;
    eau_pkg::t_out n_res;
    logic signed [31:0] w_prod;
    logic [15:0] w_q;
    logic [15:0] w_r;
    logic [16:0] w_qm;
    logic [5:0]  w_cnt;
    logic [5:0]  w_n;
    logic [63:0] w_ext;
    logic [63:0] w_sh;
    logic [31:0] w_pair;
    logic [31:0] w_lsv;
    logic [31:0] w_msk;
    logic [31:0] w_outb;
    logic [31:0] w_d;
    logic        w_qneg;

    always_comb begin
        n_res  = '0;
        w_prod = $signed(i_d.hi) * $signed(i_d.src);
        w_cnt  = i_d.src[5:0];
        w_n    = 6'd0 - w_cnt;
        w_pair = {i_d.hi, i_d.lo};
        w_qneg = i_d.sdvd ^ i_d.sdiv;
        // quotient magnitude: the 16 bits shifted in by the cells
        w_qm   = {1'b0, i_d.dvd[15:0]};
        w_q    = w_qneg ? (16'd0 - i_d.dvd[15:0]) : i_d.dvd[15:0];
        w_r    = i_d.sdvd ? (16'd0 - i_d.rem[15:0]) : i_d.rem[15:0];
        w_ext  = '0;
        w_sh   = '0;
        w_lsv  = '0;
        w_msk  = '0;
        w_outb = '0;
        w_d    = '0;
        unique case (i_d.op)
            eau_pkg::OP_MUL: begin
                n_res.result_high = w_prod[31:16];
                n_res.result_low  = w_prod[15:0];
                n_res.write_high  = 1'b1;
                n_res.write_low   = 1'b1;
                n_res.flags_out[3] = w_prod[31];
                n_res.flags_out[2] = (w_prod == 32'sd0);
                n_res.flags_out[0] = (w_prod[31:15] != {17{w_prod[15]}});
            end
            eau_pkg::OP_DIV: begin
                if (i_d.src == 16'd0) begin
                    n_res.flags_out = 4'b0111;
                end else if (w_pair == 32'h8000_0000 && i_d.src == 16'hffff) begin
                    n_res.flags_out = 4'b0010;
                end else if (!w_qneg && (i_d.ovf || w_qm[15])) begin
                    n_res.flags_out = 4'b0010;
                end else if (w_qneg && (i_d.ovf || w_qm > 17'h08000)) begin
                    n_res.flags_out = {2'b10, 2'b10} | {1'b0, i_d.fin[2], 2'b00};
                end else begin
                    n_res.result_high = w_q;
                    n_res.result_low  = w_r;
                    n_res.write_high  = 1'b1;
                    n_res.write_low   = 1'b1;
                    n_res.flags_out[3] = w_q[15];
                    n_res.flags_out[2] = (w_q == 16'd0);
                end
            end
            eau_pkg::OP_ASH: begin
                if (w_cnt[5]) begin
                    w_ext = {{48{i_d.hi[15]}}, i_d.hi} >> (w_n - 6'd1);
                    n_res.flags_out[0] = w_ext[0];
                    n_res.result_high  = w_ext[16:1];
                end else begin
                    w_lsv = {16'd0, i_d.hi} << w_cnt[4:0];
                    if (w_cnt[4:0] == 5'd0) w_lsv = {16'd0, i_d.hi};
                    w_msk = 32'h0000_ffff << w_cnt[4:0];
                    n_res.flags_out[1] = ((w_lsv[31:16] != 16'd0) &&
                        (w_lsv[31:16] != w_msk[31:16])) || (w_lsv[15] != i_d.hi[15]);
                    n_res.flags_out[0] = w_lsv[16];
                    n_res.result_high  = w_lsv[15:0];
                end
                n_res.write_high   = 1'b1;
                n_res.flags_out[2] = (n_res.result_high == 16'd0);
                n_res.flags_out[3] = n_res.result_high[15];
            end
            eau_pkg::OP_ASHC: begin
                if (w_cnt == 6'd0) begin
                    w_d = w_pair;
                end else if (!w_cnt[5]) begin
                    w_sh   = {{32{w_pair[31]}}, w_pair} << w_cnt;
                    w_outb = w_sh[63:32];
                    w_d    = w_sh[31:0];
                    n_res.flags_out[1] = (w_outb != {32{w_d[31]}});
                    n_res.flags_out[0] = w_outb[0];
                end else begin
                    w_ext = {{32{w_pair[31]}}, w_pair} >> (w_n - 6'd1);
                    n_res.flags_out[0] = w_ext[0];
                    w_d = w_ext[32:1];
                end
                n_res.result_high  = w_d[31:16];
                n_res.result_low   = w_d[15:0];
                n_res.write_high   = 1'b1;
                n_res.write_low    = 1'b1;
                n_res.flags_out[3] = w_d[31];
                n_res.flags_out[2] = (w_d == 32'd0);
            end
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_d.vld;
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* rtl/core/extended_arith_unit_top.sv */
// From start to o_done an item passes the entry stage, 16 divide cells and the exit stage.
// Throughput: one item per cycle for every operation; busy stays low.
// The divide runs one quotient bit per cell down the 16-cell chain.
// Reset (synchronous, active low) clears every stage valid; no result follows.
// The receiver cannot stall: o_done pulses for one cycle per item.
module extended_arith_unit_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  eau_pkg::t_in  i_item,
    output logic          o_done,
    output eau_pkg::t_out o_result
);

    eau_pkg::t_stage w_chain [eau_pkg::NumCells+1];

    assign busy = 1'b0;

    eau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_item  (i_item),
        .o_d     (w_chain[0])
    );

    for (genvar g = 0; g < eau_pkg::NumCells; g++) begin : g_cell
        eau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    eau_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_d      (w_chain[eau_pkg::NumCells]),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

/* rtl/core/eau_checker.sv */
module eau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input eau_pkg::t_out o_result
);

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!start, 18) && $past(i_rst_n, 18) |-> !o_done)
        else $error("result without item");

    a_item_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start, 18) && $past(i_rst_n, 18) |-> o_done)
        else $error("item lost");

    a_wl_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.write_low |-> o_result.write_high)
        else $error("low write alone");

    a_no_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.write_high |-> o_result.result_high == 16'd0)
        else $error("data without write");

endmodule

bind extended_arith_unit_top eau_checker u_eau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
